// File: hw/rtl/radical_inverse_prime_base_macros.svh
// assertion macros shared by the checker
`ifndef RADICAL_INVERSE_PRIME_BASE_MACROS_SVH
`define RADICAL_INVERSE_PRIME_BASE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RIP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rip_pkg.sv
package rip_pkg;

  // width of the base selector and of a prime base
  localparam int SEL_W = 6;
  localparam int BASE_W = 9;

  // index bits consumed by the digit divider per cycle
  localparam int DIGIT_STEP = 8;

  // the first 64 primes
  localparam logic [BASE_W-1:0] PRIMES [64] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIGIT = 4'b0010,
    ST_FRAC  = 4'b0100,
    ST_HOLD  = 4'b1000
  } rip_state_t;

  function automatic logic [BASE_W-1:0] prime_of(input logic [SEL_W-1:0] sel);
    return PRIMES[sel];
  endfunction

endpackage

// File: hw/rtl/rip_digit_div.sv
module rip_digit_div #(
  parameter int STEPS = 8
) (
  input  logic [rip_pkg::BASE_W-1:0] divisor,
  input  logic [rip_pkg::BASE_W-1:0] rem_in,
  input  logic [STEPS-1:0]           bits,
  output logic [rip_pkg::BASE_W-1:0] rem_out,
  output logic [STEPS-1:0]           quo
);
  import rip_pkg::*;

  // restoring division by a small prime, several index bits msb first
  always_comb begin
    logic [BASE_W:0]   trial;
    logic [BASE_W-1:0] r;
    r = rem_in;
    quo = '0;
    for (int i = STEPS - 1; i >= 0; i--) begin
      trial = {r, bits[i]};
      if (trial >= {1'b0, divisor}) begin
        r = BASE_W'(trial - {1'b0, divisor});
        quo[i] = 1'b1;
      end else begin
        r = trial[BASE_W-1:0];
        quo[i] = 1'b0;
      end
    end
    rem_out = r;
  end

endmodule

// File: hw/rtl/radical_inverse_prime_base.sv
// one item at a time; the index is split into CHUNKS = ceil(INDEX_BITS / 8) chunks, which
// the 8-bit-per-cycle digit divider works through once for each digit of the index in
// the chosen base, and the one-bit-per-cycle fraction division then forms the FRACTION_BITS
// result bits; a finished result may wait in the output register while a new item runs
// synchronous reset returns the sequencer to idle and drops out_valid
module radical_inverse_prime_base #(
  parameter int PRIME_COUNT   = 64,
  parameter int INDEX_BITS    = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rip_pkg::SEL_W-1:0]  base_select,
  input  logic [INDEX_BITS-1:0]      sample_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [FRACTION_BITS-1:0]   fraction
);
  import rip_pkg::*;

  localparam int CHUNKS  = (INDEX_BITS + DIGIT_STEP - 1) / DIGIT_STEP;
  localparam int IDX_W   = CHUNKS * DIGIT_STEP;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DEN_W   = INDEX_BITS + BASE_W;
  localparam int PROD_W  = DEN_W + BASE_W;
  localparam int FCNT_W  = $clog2(FRACTION_BITS);

  rip_state_t state, state_next;

  logic [IDX_W-1:0]         idx;
  logic [CHUNK_W-1:0]       chunk;
  logic [BASE_W-1:0]        dig_rem;
  logic [BASE_W-1:0]        digit;
  logic                     pend;
  logic [BASE_W-1:0]        base;
  logic [DEN_W-1:0]         rev;
  logic [DEN_W-1:0]         den;
  logic [FCNT_W-1:0]        fcnt;
  logic [FRACTION_BITS-1:0] quot;

  logic [SEL_W-1:0]         sel_sat;
  logic                     chunk_first;
  logic                     chunk_last;
  logic                     idx_zero;
  logic                     digits_done;
  logic                     frac_last;
  logic                     out_free;
  logic [BASE_W-1:0]        div_rem_in;
  logic [BASE_W-1:0]        div_rem;
  logic [DIGIT_STEP-1:0]    div_quo;
  logic [IDX_W+DIGIT_STEP-1:0] idx_wide;
  logic [PROD_W-1:0]        rev_prod;
  logic [PROD_W-1:0]        den_prod;
  logic [DEN_W-1:0]         rev_upd;
  logic [DEN_W:0]           rem2;
  logic [DEN_W:0]           rem_sub;
  logic                     take;
  logic [DEN_W-1:0]         rev_frac;

  // selector saturates to the last of the first PRIME_COUNT primes in the table
  assign sel_sat = ({1'b0, base_select} >= (SEL_W + 1)'(PRIME_COUNT))
                   ? SEL_W'(PRIME_COUNT - 1) : base_select;

  assign chunk_first = (chunk == '0);
  assign chunk_last  = (chunk == CHUNK_W'(CHUNKS - 1));
  assign idx_zero    = (idx == '0);
  assign digits_done = chunk_first && idx_zero;
  assign frac_last   = (fcnt == FCNT_W'(FRACTION_BITS - 1));
  assign out_free    = !out_valid || !out_stall;

  // shared digit divider, one chunk of the index per cycle
  assign div_rem_in = chunk_first ? '0 : dig_rem;

  rip_digit_div #(
    .STEPS(DIGIT_STEP)
  ) u_digit_div (
    .divisor(base),
    .rem_in (div_rem_in),
    .bits   (idx[IDX_W-1 -: DIGIT_STEP]),
    .rem_out(div_rem),
    .quo    (div_quo)
  );

  assign idx_wide = {idx, div_quo};

  // fold the last digit into the reversed value and the base power
  assign rev_prod = PROD_W'(rev) * PROD_W'(base);
  assign den_prod = PROD_W'(den) * PROD_W'(base);
  assign rev_upd  = rev_prod[DEN_W-1:0] + DEN_W'(digit);

  // restoring division step for the output fraction
  assign rem2     = {rev, 1'b0};
  assign take     = (rem2 >= {1'b0, den});
  assign rem_sub  = rem2 - {1'b0, den};
  assign rev_frac = take ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];

  assign in_stall = (state != ST_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIGIT;
      ST_DIGIT: if (digits_done) state_next = ST_FRAC;
      ST_FRAC:  if (frac_last) state_next = ST_HOLD;
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        pend <= 1'b0;
      end else if (state == ST_DIGIT) begin
        pend <= !digits_done && chunk_last;
      end
      if (state == ST_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          idx   <= IDX_W'(sample_index);
          base  <= prime_of(sel_sat);
          rev   <= '0;
          den   <= DEN_W'(1);
          chunk <= '0;
          fcnt  <= '0;
        end
      end
      ST_DIGIT: begin
        if (pend) begin
          rev <= rev_upd;
          den <= den_prod[DEN_W-1:0];
        end
        if (!digits_done) begin
          idx     <= idx_wide[IDX_W-1:0];
          dig_rem <= div_rem;
          if (chunk_last) begin
            chunk <= '0;
            digit <= div_rem;
          end else begin
            chunk <= CHUNK_W'(chunk + 1'b1);
          end
        end
      end
      ST_FRAC: begin
        rev  <= rev_frac;
        quot <= {quot[FRACTION_BITS-2:0], take};
        fcnt <= FCNT_W'(fcnt + 1'b1);
      end
      ST_HOLD: begin
        if (out_free) begin
          fraction <= quot;
        end
      end
      default: begin
        fcnt <= '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/rip_checker.sv
`include "radical_inverse_prime_base_macros.svh"

module rip_checker #(
  parameter int FRACTION_BITS = 24
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [FRACTION_BITS-1:0] fraction
);

  // an accepted item keeps the block busy in the next cycle
  `RIP_ASSERT_NEXT(a_busy_after_accept, clk, rst,
                   in_valid && !in_stall, in_stall,
                   "not busy after accept")

  // a waiting result holds
  `RIP_ASSERT_NEXT(a_result_held, clk, rst,
                   out_valid && out_stall, out_valid && $stable(fraction),
                   "stalled result changed")

  // a new result only appears at the end of a busy stretch
  `RIP_ASSERT_NOW(a_result_after_work, clk, rst,
                  $rose(out_valid), $past(in_stall),
                  "result without work")

  // reset leaves the block idle with no result
  `RIP_ASSERT_NOW(a_idle_after_reset, clk, rst,
                  $past(rst), !out_valid && !in_stall,
                  "not idle after reset")

endmodule

bind radical_inverse_prime_base rip_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_rip_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .fraction (fraction)
);
